// ===== design/pttach_pkg.sv =====
// Shared types, constants and codes for the pulse timestamp tachometer.
package pttach_pkg;

   // Stamp ring geometry
   localparam int DEPTH   = 3;
   localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int AGE_W   = 20;
   localparam int RPM_W   = 24;
   localparam int CNT_W   = 5;
   localparam int OFF_W   = TIME_W + 1;

   // rpm_x16 numerator: (count-1) * 60000 * 16
   localparam int SCALE_W = 20;
   localparam logic [SCALE_W-1:0] NUM_SCALE = SCALE_W'(960000);
   localparam int NUM_W   = RPM_W;
   localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

   // Shared step counter covers the ring scan and the divide iterations
   localparam int STEP_W  = $clog2((DEPTH > NUM_W) ? DEPTH : NUM_W);

   // Configuration
   localparam int CSR_AW  = 3;
   localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(6000);
   localparam logic REG_MAX_AGE = 1'b0;

   // Input word kinds
   localparam logic FUNC_PULSE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic record;
      logic scan_start;
      logic scan_step;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ===== design/pttach_ctrl.sv =====
// Sequencer for the tachometer: record, ring scan, divide and result hand-off.
module pttach_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_func,
   input  pttach_pkg::status_type  status,
   output logic                    req_tready,
   output pttach_pkg::cmd_type     cmd
);

   pttach_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pttach_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pttach_pkg::ST_IDLE: begin
            if (req_tvalid && req_func == pttach_pkg::FUNC_QUERY) begin
               state_in = pttach_pkg::ST_SCAN;
            end
         end
         pttach_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = pttach_pkg::ST_DIV_LOAD;
            end
         end
         pttach_pkg::ST_DIV_LOAD: begin
            state_in = pttach_pkg::ST_DIV;
         end
         pttach_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = pttach_pkg::ST_DONE;
            end
         end
         pttach_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = pttach_pkg::ST_IDLE;
            end
         end
         default: state_in = pttach_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pttach_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.record     = req_tvalid && (req_func == pttach_pkg::FUNC_PULSE);
            cmd.scan_start = req_tvalid && (req_func == pttach_pkg::FUNC_QUERY);
         end
         pttach_pkg::ST_SCAN:     cmd.scan_step = 1'b1;
         pttach_pkg::ST_DIV_LOAD: cmd.div_load  = 1'b1;
         pttach_pkg::ST_DIV:      cmd.div_step  = 1'b1;
         pttach_pkg::ST_DONE:     cmd.out_load  = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== design/pttach_dp.sv =====
// Tachometer datapath: stamp ring, freshness scan, restoring divider, result register.
module pttach_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  pttach_pkg::cmd_type               cmd,
   output pttach_pkg::status_type            status,
   input  logic [pttach_pkg::TIME_W-1:0]     now_ms,
   input  logic [pttach_pkg::AGE_W-1:0]      max_age_ms,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [pttach_pkg::RPM_W-1:0]      rpm_x16,
   output logic [pttach_pkg::CNT_W-1:0]      points_used,
   output logic                              no_reading
);

   // Stamp ring and its valid bits
   logic [pttach_pkg::TIME_W-1:0] ring_ff [pttach_pkg::DEPTH];
   logic [pttach_pkg::DEPTH-1:0]  valid_ff;
   logic [pttach_pkg::SLOT_W-1:0] wslot_ff;

   // Scan state
   logic [pttach_pkg::TIME_W-1:0]        now_ff;
   logic [pttach_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [pttach_pkg::CNT_W-1:0]         count_ff, count_in;
   logic signed [pttach_pkg::OFF_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;

   // Divider state
   logic [pttach_pkg::OFF_W-1:0]  span_ff;
   logic [pttach_pkg::OFF_W-1:0]  rem_ff, rem_in;
   logic [pttach_pkg::NUM_W-1:0]  quo_ff, quo_in;
   logic                          zero_span_ff;
   logic                          reading_ff;

   // Result register
   logic                          rsp_valid_ff;
   logic [pttach_pkg::RPM_W-1:0]  rpm_ff;
   logic [pttach_pkg::CNT_W-1:0]  points_ff;
   logic                          no_reading_ff;

   // Freshness test of the slot under scan
   logic [pttach_pkg::SLOT_W-1:0]       idx;
   logic [pttach_pkg::TIME_W-1:0]       diff;
   logic signed [pttach_pkg::OFF_W-1:0] off;
   logic [pttach_pkg::OFF_W-1:0]        age;
   logic                                fresh;

   assign idx   = step_ff[pttach_pkg::SLOT_W-1:0];
   assign diff  = ring_ff[idx] - now_ff;
   assign off   = $signed({diff[pttach_pkg::TIME_W-1], diff});
   assign age   = off[pttach_pkg::OFF_W-1] ? pttach_pkg::OFF_W'(-off)
                                           : pttach_pkg::OFF_W'(off);
   assign fresh = valid_ff[idx] &&
                  (age < {{(pttach_pkg::OFF_W-pttach_pkg::AGE_W){1'b0}}, max_age_ms});

   // Numerator and span for the divide
   logic [pttach_pkg::CNT_W-1:0]                    cnt_less;
   logic [pttach_pkg::CNT_W+pttach_pkg::SCALE_W-1:0] num_wide;
   logic                                            reading;
   logic [pttach_pkg::OFF_W-1:0]                    span;

   assign cnt_less = count_ff - pttach_pkg::CNT_W'(1);
   assign num_wide = cnt_less * pttach_pkg::NUM_SCALE;
   assign reading  = count_ff >= pttach_pkg::CNT_W'(2);
   assign span     = pttach_pkg::OFF_W'(hi_ff - lo_ff);

   // One restoring divide step
   logic [pttach_pkg::OFF_W:0] rem_shift;
   logic                       rem_ge;

   assign rem_shift = {rem_ff, quo_ff[pttach_pkg::NUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, span_ff};

   // Ring writes
   always_ff @(posedge clock) begin
      if (cmd.record) begin
         ring_ff[wslot_ff] <= now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wslot_ff <= '0;
      end else if (cmd.record) begin
         valid_ff[wslot_ff] <= 1'b1;
         if (wslot_ff == pttach_pkg::SLOT_W'(pttach_pkg::DEPTH-1)) begin
            wslot_ff <= '0;
         end else begin
            wslot_ff <= wslot_ff + pttach_pkg::SLOT_W'(1);
         end
      end
   end

   // Scan accumulators and step counter
   always_comb begin
      step_in  = step_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      priority if (cmd.scan_start) begin
         step_in  = '0;
         count_in = '0;
      end else if (cmd.scan_step) begin
         step_in = step_ff + pttach_pkg::STEP_W'(1);
         if (fresh) begin
            count_in = count_ff + pttach_pkg::CNT_W'(1);
            if (count_ff == '0 || off < lo_ff) lo_in = off;
            if (count_ff == '0 || off > hi_ff) hi_in = off;
         end
      end else if (cmd.div_load) begin
         step_in = '0;
         rem_in  = '0;
         quo_in  = reading ? num_wide[pttach_pkg::NUM_W-1:0] : '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + pttach_pkg::STEP_W'(1);
         rem_in  = rem_ge ? pttach_pkg::OFF_W'(rem_shift - {1'b0, span_ff})
                          : rem_shift[pttach_pkg::OFF_W-1:0];
         quo_in  = {quo_ff[pttach_pkg::NUM_W-2:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.scan_start) begin
         now_ff <= now_ms;
      end
      if (cmd.div_load) begin
         span_ff      <= span;
         zero_span_ff <= (span == '0);
         reading_ff   <= reading;
      end
   end

   // Result register, freed when the receiver takes the word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rpm_ff        <= !reading_ff ? '0 : (zero_span_ff ? pttach_pkg::RPM_MAX : quo_ff);
         points_ff     <= count_ff;
         no_reading_ff <= !reading_ff;
      end
   end

   assign status.scan_last = (step_ff == pttach_pkg::STEP_W'(pttach_pkg::DEPTH-1));
   assign status.div_last  = (step_ff == pttach_pkg::STEP_W'(pttach_pkg::NUM_W-1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign rpm_x16     = rpm_ff;
   assign points_used = points_ff;
   assign no_reading  = no_reading_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pttach_pkg::CNT_W'(pttach_pkg::DEPTH))
      else $error("fresh stamp count exceeds ring depth");

   a_wslot_bound: assert property (@(posedge clock) disable iff (reset)
      wslot_ff <= pttach_pkg::SLOT_W'(pttach_pkg::DEPTH-1))
      else $error("write slot out of ring range");

   a_no_reading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && no_reading_ff |-> rpm_ff == '0)
      else $error("rpm not zero without a reading");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// ===== design/pulse_timestamp_tachometer_core.sv =====
// Top level of the pulse timestamp tachometer: stream ports, register port, core wiring.
//
// Input words arrive on req_*: tuser selects a sensor pulse (0) or a speed query (1),
// tdata carries the current millisecond time. A pulse is stored in the stamp ring in
// the cycle it is accepted and produces no output word. A query scans the DEPTH stamps
// one per cycle, then runs a 24-step restoring divide, and returns one word on rsp_*:
// rpm times 16, the count of fresh stamps, and a no-reading flag in tuser.
// A query passes through the serial ring scan, a divider load, the one-bit-per-cycle
// divide and a done state before its word reaches the result register. Only one
// query is in work at a time; req_tready is high only while the sequencer is idle.
// The result register holds a finished word while rsp_tready is low; the block still
// takes new pulses and starts the next query, which then waits in its last step
// until the register frees.
// max_age_ms sits at byte address 0 of the APB-style port (pready always high);
// synchronous reset sets it to 6000, clears all stamp valid bits, the write slot,
// and drops any pending result.
module pulse_timestamp_tachometer_core (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] now_ms
   input  logic        req_tuser,   // [0] func
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [23:0] rpm_x16, [28:24] points_used, [31:29] zero
   output logic        rsp_tuser,   // [0] no_reading
   // Register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pttach_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   pttach_pkg::cmd_type    cmd;
   pttach_pkg::status_type status;

   logic [pttach_pkg::AGE_W-1:0] max_age_ff;
   logic [pttach_pkg::RPM_W-1:0] rpm_x16;
   logic [pttach_pkg::CNT_W-1:0] points_used;
   logic                         csr_hit;

   // Register file: a single age limit, one word per 4 bytes
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[pttach_pkg::CSR_AW-1] == pttach_pkg::REG_MAX_AGE);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= pttach_pkg::AGE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         max_age_ff <= csr_pwdata[pttach_pkg::AGE_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? {{(32-pttach_pkg::AGE_W){1'b0}}, max_age_ff} : '0;

   pttach_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   pttach_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .now_ms      (req_tdata),
      .max_age_ms  (max_age_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rpm_x16     (rpm_x16),
      .points_used (points_used),
      .no_reading  (rsp_tuser)
   );

   // Result word packing
   assign rsp_tdata = {3'b000, points_used, rpm_x16};

endmodule
